// ===== sv/qpd_pkg.sv =====
// ----------------------------------------------------------------------------
// qpd_pkg
// shared types and constants of the quantized pot debouncer
// ----------------------------------------------------------------------------
package qpd_pkg;

    localparam int MAX_RANGES = 4;
    localparam int BOUND_REGS = 4;

    localparam int SAMPLE_W    = 10;
    localparam int INDEX_W     = 3;
    localparam int VELOCITY_W  = SAMPLE_W + 1;
    localparam int COUNT_W     = 3;
    localparam int THRESHOLD_W = 8;
    localparam int MISMATCH_W  = 9;
    localparam int BOUNDS_W    = 2 * SAMPLE_W;

    localparam int NUM_RANGES  = (MAX_RANGES < BOUND_REGS) ? MAX_RANGES : BOUND_REGS;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_SEL_W   = 3;

    localparam logic [REG_SEL_W-1:0] REG_RANGE_COUNT = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_THRESHOLD   = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_BOUNDS_0    = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_BOUNDS_1    = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_BOUNDS_2    = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_BOUNDS_3    = 3'd5;

    localparam logic signed [INDEX_W-1:0] INDEX_NONE = -3'sd1;
    localparam logic [MISMATCH_W-1:0]     MISMATCH_MAX = '1;

    typedef logic [SAMPLE_W-1:0]          sample_t;
    typedef logic signed [INDEX_W-1:0]    index_t;
    typedef logic signed [VELOCITY_W-1:0] velocity_t;
    typedef logic [COUNT_W-1:0]           count_t;
    typedef logic [THRESHOLD_W-1:0]       threshold_t;
    typedef logic [MISMATCH_W-1:0]        mismatch_t;
    typedef logic [BOUNDS_W-1:0]          bounds_t;
    typedef bounds_t                      bounds_arr_t [BOUND_REGS];

endpackage

// ===== sv/qpd_quant.sv =====
// ----------------------------------------------------------------------------
// qpd_quant
// parallel range comparators, lowest matching range wins
// ----------------------------------------------------------------------------
module qpd_quant
(
    input  qpd_pkg::sample_t     sample,
    input  qpd_pkg::count_t      range_count,
    input  qpd_pkg::bounds_arr_t bounds,
    output qpd_pkg::index_t      raw_index
);
    import qpd_pkg::*;

    count_t count_clamped;
    logic [NUM_RANGES-1:0] hit;

    assign count_clamped = (range_count > COUNT_W'(NUM_RANGES)) ?
                           COUNT_W'(NUM_RANGES) : range_count;

    always_comb
    begin
        for (int i = 0; i < NUM_RANGES; i++)
        begin
            hit[i] = (COUNT_W'(i) < count_clamped)
                  && (sample >= bounds[i][SAMPLE_W-1:0])
                  && (sample <= bounds[i][BOUNDS_W-1:SAMPLE_W]);
        end
    end

    always_comb
    begin
        raw_index = INDEX_NONE;
        for (int i = NUM_RANGES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                raw_index = INDEX_W'(i);
            end
        end
    end

endmodule

// ===== sv/quantized_pot_debouncer.sv =====
// ----------------------------------------------------------------------------
// quantized_pot_debouncer
// quantizes adc samples to configured ranges and debounces the range index
// ----------------------------------------------------------------------------
// an accepted input word passes the input register, then the result register, 2 registers
// throughput: one word per cycle while out_stall is low, input register feeds the result register
// the input side stalls only when both stages hold a word and the output stalls
// reset: asynchronous, clears valids, config registers and debounce state to 0
// ----------------------------------------------------------------------------
module quantized_pot_debouncer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [qpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  qpd_pkg::sample_t                    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output qpd_pkg::index_t                     debounced_index,
    output qpd_pkg::index_t                     raw_index,
    output qpd_pkg::velocity_t                  velocity,
    output logic                                state_changed
);
    import qpd_pkg::*;

    // config registers
    count_t      range_count_reg;
    threshold_t  threshold_reg;
    bounds_arr_t bounds_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic        cfg_write;

    // input stage
    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t s1_sample_reg;
    logic    in_accept;
    logic    s1_advance;

    // debounce state
    index_t    current_index_reg;
    index_t    current_index_next;
    mismatch_t mismatch_count_reg;
    mismatch_t mismatch_count_next;
    sample_t   previous_sample_reg;

    // result stage
    logic      out_valid_reg;
    logic      out_valid_next;
    index_t    debounced_index_reg;
    index_t    raw_index_reg;
    velocity_t velocity_reg;
    logic      state_changed_reg;

    index_t    quant_index;
    mismatch_t mismatch_inc;
    logic      change;
    velocity_t velocity_calc;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= '0;
            threshold_reg   <= '0;
            for (int i = 0; i < BOUND_REGS; i++)
            begin
                bounds_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_RANGE_COUNT: range_count_reg <= pwdata[COUNT_W-1:0];
                REG_THRESHOLD:   threshold_reg   <= pwdata[THRESHOLD_W-1:0];
                REG_BOUNDS_0:    bounds_reg[0]   <= pwdata[BOUNDS_W-1:0];
                REG_BOUNDS_1:    bounds_reg[1]   <= pwdata[BOUNDS_W-1:0];
                REG_BOUNDS_2:    bounds_reg[2]   <= pwdata[BOUNDS_W-1:0];
                REG_BOUNDS_3:    bounds_reg[3]   <= pwdata[BOUNDS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RANGE_COUNT: prdata = APB_DATA_W'(range_count_reg);
            REG_THRESHOLD:   prdata = APB_DATA_W'(threshold_reg);
            REG_BOUNDS_0:    prdata = APB_DATA_W'(bounds_reg[0]);
            REG_BOUNDS_1:    prdata = APB_DATA_W'(bounds_reg[1]);
            REG_BOUNDS_2:    prdata = APB_DATA_W'(bounds_reg[2]);
            REG_BOUNDS_3:    prdata = APB_DATA_W'(bounds_reg[3]);
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
        end
    end

    qpd_quant u_quant
    (
        .sample      (s1_sample_reg),
        .range_count (range_count_reg),
        .bounds      (bounds_reg),
        .raw_index   (quant_index)
    );

    // debounce update
    assign velocity_calc = velocity_t'({1'b0, s1_sample_reg})
                         - velocity_t'({1'b0, previous_sample_reg});

    always_comb
    begin
        mismatch_inc        = (mismatch_count_reg < MISMATCH_MAX) ?
                              mismatch_count_reg + 1'b1 : mismatch_count_reg;
        change              = 1'b0;
        current_index_next  = current_index_reg;
        mismatch_count_next = '0;
        if (quant_index != current_index_reg)
        begin
            if (mismatch_inc > MISMATCH_W'(threshold_reg))
            begin
                change             = 1'b1;
                current_index_next = quant_index;
            end
            else
            begin
                mismatch_count_next = mismatch_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            current_index_reg   <= '0;
            mismatch_count_reg  <= '0;
            previous_sample_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                current_index_reg   <= current_index_next;
                mismatch_count_reg  <= mismatch_count_next;
                previous_sample_reg <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            debounced_index_reg <= current_index_next;
            raw_index_reg       <= quant_index;
            velocity_reg        <= velocity_calc;
            state_changed_reg   <= change;
        end
    end

    assign out_valid       = out_valid_reg;
    assign debounced_index = debounced_index_reg;
    assign raw_index       = raw_index_reg;
    assign velocity        = velocity_reg;
    assign state_changed   = state_changed_reg;

endmodule

// ===== sv/qpd_checker.sv =====
// ----------------------------------------------------------------------------
// qpd_checker
// port level checks of the quantized pot debouncer
// ----------------------------------------------------------------------------
module qpd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input qpd_pkg::index_t                 debounced_index,
    input qpd_pkg::index_t                 raw_index,
    input qpd_pkg::velocity_t              velocity,
    input logic                            state_changed
);
    import qpd_pkg::*;

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(debounced_index) && $stable(raw_index)
                                   && $stable(velocity) && $stable(state_changed))
        else $error("stalled output word changed");

    // a state change always lands on the raw index of the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && state_changed |-> debounced_index == raw_index)
        else $error("state change to an index other than the raw index");

    // input never stalls while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

endmodule

bind quantized_pot_debouncer qpd_checker u_qpd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .debounced_index (debounced_index),
    .raw_index       (raw_index),
    .velocity        (velocity),
    .state_changed   (state_changed)
);
